// ----- design/efa_pkg.sv -----
// ----------------------------------------------------------------------------
// efa_pkg
// shared constants for the exact-fit free-list allocator: defaults, field
// widths, chunk sizing, action/status codes, configuration register indexes
// ----------------------------------------------------------------------------
package efa_pkg;

  // parameter defaults
  localparam int DEF_FREE_ENTRIES = 64;
  localparam int DEF_ADDR_BITS    = 32;
  localparam int DEF_SIZE_BITS    = 25;

  // fixed field widths
  localparam int REQ_BITS      = 24;
  localparam int CHUNK_BITS    = REQ_BITS + 1;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_IDX_BITS  = 2;
  localparam int STATUS_BITS   = 3;

  // chunk size arithmetic
  localparam int HEADER_BYTES = 8;
  localparam int ROUND_ADD    = 15;
  localparam int ALIGN_BYTES  = 8;

  // action codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // status codes
  localparam logic [STATUS_BITS-1:0] ST_OK   = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_ZERO = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_OOM  = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_FULL = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_NULL = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_HEAP_TOP   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEAP_FLOOR = 2'd1;

endpackage

// ----- design/exact_fit_free_list_allocator_top.sv -----
// ----------------------------------------------------------------------------
// exact_fit_free_list_allocator_top
// exact-fit free-list allocator with a downward bump pointer
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears on result_address, granted_size and status for one cycle, marked by
// done, and must be captured then since the receiver cannot stall. A free, a
// null free, a table-full free and a zero-byte allocate finish in S_EXEC,
// which raises done. An allocate searches the freed-chunk table from the most
// recent entry down, one entry per cycle through the table's single read
// port; on a hit at index i the younger entries are moved down one place, one
// per cycle, to keep their order, and S_FINISH then raises done; on a miss
// S_MISS falls back to the bump pointer. busy stays high for the whole item.
// The table holds no valid bits: only entries below the fill count are ever
// used.
// Configuration writes are taken while idle; writing heap_top also reloads
// the bump pointer.
// ----------------------------------------------------------------------------
module exact_fit_free_list_allocator_top #(
  parameter int FREE_ENTRIES = efa_pkg::DEF_FREE_ENTRIES,
  parameter int ADDR_BITS    = efa_pkg::DEF_ADDR_BITS,
  parameter int SIZE_BITS    = efa_pkg::DEF_SIZE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                action,
  input  logic [efa_pkg::REQ_BITS-1:0]        request_bytes,
  input  logic [ADDR_BITS-1:0]                data_address,
  input  logic [SIZE_BITS-1:0]                header_size,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [efa_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [efa_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  // result channel
  output logic                                done,
  output logic [ADDR_BITS-1:0]                result_address,
  output logic [SIZE_BITS-1:0]                granted_size,
  output logic [efa_pkg::STATUS_BITS-1:0]     status
);

  localparam int CB        = efa_pkg::CHUNK_BITS;
  localparam int IDX_BITS  = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
  localparam int CNT_BITS  = $clog2(FREE_ENTRIES + 1);
  localparam int CNT1_BITS = CNT_BITS + 1;
  // width for comparing a chunk size against a stored length
  localparam int LW        = (SIZE_BITS > CB) ? SIZE_BITS : CB;
  // width for comparing a chunk size against an address gap
  localparam int GW        = (ADDR_BITS > CB) ? ADDR_BITS : CB;
  localparam int ENT_BITS  = ADDR_BITS + SIZE_BITS;

  localparam logic [LW-1:0] SIZE_MAX = LW'((65'd1 << SIZE_BITS) - 65'd1);
  localparam logic [CB-1:0] ROUND_ADD_C = CB'(efa_pkg::ROUND_ADD);
  localparam logic [CB-1:0] ALIGN_MASK  = ~CB'(efa_pkg::ALIGN_BYTES - 1);
  localparam logic [ADDR_BITS-1:0] HDR_C = ADDR_BITS'(efa_pkg::HEADER_BYTES);
  localparam logic [CNT_BITS-1:0]  FULL_C = CNT_BITS'(FREE_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_SHIFT,
    S_MISS,
    S_FINISH
  } state_t;

  state_t state;

  // latched item
  logic                    act_q;
  logic                    zero_req;
  logic [CB-1:0]           size_q;
  logic [ADDR_BITS-1:0]    data_q;
  logic [SIZE_BITS-1:0]    hsize_q;

  // allocator state
  logic [ADDR_BITS-1:0]    bump;
  logic [ADDR_BITS-1:0]    floor_q;
  logic [CNT_BITS-1:0]     count;

  // working registers
  logic [CNT_BITS-1:0]     idx;
  logic [ADDR_BITS-1:0]    base;
  logic [ADDR_BITS-1:0]    gap;
  logic                    below;

  // free table
  logic [ENT_BITS-1:0]     mem [FREE_ENTRIES];
  logic [ENT_BITS-1:0]     rd_q;
  logic [IDX_BITS-1:0]     rd_idx;
  logic                    mem_we;
  logic [IDX_BITS-1:0]     mem_wa;
  logic [ENT_BITS-1:0]     mem_wd;

  logic [ADDR_BITS-1:0]    rd_addr;
  logic [SIZE_BITS-1:0]    rd_len;
  logic                    hit;
  logic                    fits;
  logic [CNT1_BITS-1:0]    idx_p1;
  logic [CNT1_BITS-1:0]    idx_p2;
  logic [CNT1_BITS-1:0]    idx_m1;
  logic [CNT1_BITS-1:0]    cnt_m1;
  logic [CNT1_BITS-1:0]    cnt_x;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  assign rd_addr = rd_q[ENT_BITS-1:SIZE_BITS];
  assign rd_len  = rd_q[SIZE_BITS-1:0];

  // exact size compare, the unit the search loop reuses every cycle
  assign hit = (LW'(rd_len) == LW'(size_q));

  // bump fallback check: size fits the field and stays above the floor
  assign fits = !below && (LW'(size_q) <= SIZE_MAX) && (GW'(size_q) <= GW'(gap));

  assign cnt_x  = CNT1_BITS'(count);
  assign idx_p1 = CNT1_BITS'(idx) + CNT1_BITS'(1);
  assign idx_p2 = CNT1_BITS'(idx) + CNT1_BITS'(2);
  assign idx_m1 = CNT1_BITS'(idx) - CNT1_BITS'(1);
  assign cnt_m1 = cnt_x - CNT1_BITS'(1);

  // table port control
  always_comb begin
    rd_idx = idx[IDX_BITS-1:0];
    mem_we = 1'b0;
    mem_wa = count[IDX_BITS-1:0];
    mem_wd = {data_q - HDR_C, hsize_q};
    case (state)
      S_EXEC: begin
        rd_idx = cnt_m1[IDX_BITS-1:0];
        if (act_q == efa_pkg::ACT_FREE && data_q != '0 && count != FULL_C) begin
          mem_we = 1'b1;
        end
      end
      S_SEARCH: begin
        if (hit) begin
          rd_idx = idx_p1[IDX_BITS-1:0];
        end else begin
          rd_idx = idx_m1[IDX_BITS-1:0];
        end
      end
      S_SHIFT: begin
        // rd_q holds entry idx + 1, moved down into idx
        mem_we = 1'b1;
        mem_wa = idx[IDX_BITS-1:0];
        mem_wd = rd_q;
        rd_idx = idx_p2[IDX_BITS-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      bump    <= '0;
      floor_q <= '0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == efa_pkg::REG_HEAP_TOP) begin
              bump <= ADDR_BITS'(cfg_data);
            end else if (cfg_index == efa_pkg::REG_HEAP_FLOOR) begin
              floor_q <= ADDR_BITS'(cfg_data);
            end
          end
          if (start) begin
            act_q    <= action;
            zero_req <= (request_bytes == '0);
            size_q   <= (CB'(request_bytes) + ROUND_ADD_C) & ALIGN_MASK;
            data_q   <= data_address;
            hsize_q  <= header_size;
            state    <= S_EXEC;
          end
        end

        S_EXEC: begin
          gap   <= bump - floor_q;
          below <= (bump < floor_q);
          if (act_q == efa_pkg::ACT_ALLOC) begin
            if (zero_req) begin
              done           <= 1'b1;
              result_address <= '0;
              granted_size   <= '0;
              status         <= efa_pkg::ST_ZERO;
              state          <= S_IDLE;
            end else if (count == '0) begin
              state <= S_MISS;
            end else begin
              idx   <= cnt_m1[CNT_BITS-1:0];
              state <= S_SEARCH;
            end
          end else begin
            done           <= 1'b1;
            result_address <= '0;
            granted_size   <= '0;
            state          <= S_IDLE;
            if (data_q == '0) begin
              status <= efa_pkg::ST_NULL;
            end else if (count == FULL_C) begin
              status <= efa_pkg::ST_FULL;
            end else begin
              status <= efa_pkg::ST_OK;
              count  <= count + CNT_BITS'(1);
            end
          end
        end

        // newest to oldest, one entry per cycle
        S_SEARCH: begin
          if (hit) begin
            base <= rd_addr;
            if (idx_p1 < cnt_x) begin
              state <= S_SHIFT;
            end else begin
              count <= count - CNT_BITS'(1);
              state <= S_FINISH;
            end
          end else if (idx == '0) begin
            state <= S_MISS;
          end else begin
            idx <= idx_m1[CNT_BITS-1:0];
          end
        end

        // close the gap left by the removed entry
        S_SHIFT: begin
          if (idx_p2 < cnt_x) begin
            idx <= idx_p1[CNT_BITS-1:0];
          end else begin
            count <= count - CNT_BITS'(1);
            state <= S_FINISH;
          end
        end

        S_MISS: begin
          if (fits) begin
            bump  <= bump - ADDR_BITS'(size_q);
            base  <= bump - ADDR_BITS'(size_q);
            state <= S_FINISH;
          end else begin
            done           <= 1'b1;
            result_address <= '0;
            granted_size   <= '0;
            status         <= efa_pkg::ST_OOM;
            state          <= S_IDLE;
          end
        end

        S_FINISH: begin
          done           <= 1'b1;
          result_address <= base + HDR_C;
          granted_size   <= SIZE_BITS'(size_q);
          status         <= efa_pkg::ST_OK;
          state          <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // a result always closes its item
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while still busy");

  // fill count never runs past the table
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CNT1_BITS'(count) <= CNT1_BITS'(FREE_ENTRIES))
    else $error("free table count overflow");

  // an accepted item always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not start");

  // an ok grant from an allocate carries a nonzero size
  a_grant_size: assert property (@(posedge clk) disable iff (rst)
    (done && status == efa_pkg::ST_OK && act_q == efa_pkg::ACT_ALLOC) |->
    granted_size != '0)
    else $error("grant with zero size");
`endif

endmodule
